// File: rtl/mmdec_pkg.sv
// Shared constants, types and compare-order functions for the min/max decimator.
package mmdec_pkg;

    // Default channel capacity of the extreme store
    localparam int MAX_CHANNELS_DEF = 64;

    // Field widths of the stream beats
    localparam int VAL_W   = 32;
    localparam int CHIDX_W = 6;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 72;

    // Configuration register widths
    localparam int NCH_CFG_W  = 7;
    localparam int GLEN_CFG_W = 16;
    localparam int TYPE_CFG_W = 3;

    // Configuration register indexes (word addresses on the APB port)
    localparam logic [1:0] REG_NUM_CHANNELS = 2'd0;
    localparam logic [1:0] REG_GROUP_LENGTH = 2'd1;
    localparam logic [1:0] REG_SAMPLE_TYPE  = 2'd2;

    // Register reset values
    localparam logic [NCH_CFG_W-1:0]  NUM_CHANNELS_RST = 7'd1;
    localparam logic [GLEN_CFG_W-1:0] GROUP_LENGTH_RST = 16'd4;
    localparam logic [TYPE_CFG_W-1:0] SAMPLE_TYPE_RST  = 3'd4;

    // Sample type codes; unused codes fall back to float32 order
    localparam logic [TYPE_CFG_W-1:0] ST_UINT8   = 3'd0;
    localparam logic [TYPE_CFG_W-1:0] ST_INT16   = 3'd1;
    localparam logic [TYPE_CFG_W-1:0] ST_UINT16  = 3'd2;
    localparam logic [TYPE_CFG_W-1:0] ST_INT32   = 3'd3;
    localparam logic [TYPE_CFG_W-1:0] ST_FLOAT32 = 3'd4;

    // Position of one sample inside its group
    typedef struct packed {
        logic first;      // opens the group: no merge with the store
        logic last_step;  // last time step: produces a result
        logic last_ch;    // last channel of the time step
    } item_flags_t;

    // Keep only the bits that the sample type uses
    function automatic logic [VAL_W-1:0] mask_value(input logic [VAL_W-1:0] bits,
                                                     input logic [TYPE_CFG_W-1:0] st);
        logic [VAL_W-1:0] res;
        unique case (st)
            ST_UINT8:            res = {24'd0, bits[7:0]};
            ST_INT16, ST_UINT16: res = {16'd0, bits[15:0]};
            default:             res = bits;
        endcase
        return res;
    endfunction

    // Map raw bits onto an unsigned key ordered as the sample type compares
    function automatic logic [VAL_W-1:0] order_key(input logic [VAL_W-1:0] bits,
                                                    input logic [TYPE_CFG_W-1:0] st);
        logic [VAL_W-1:0] res;
        unique case (st)
            ST_UINT8:  res = {24'd0, bits[7:0]};
            ST_INT16:  res = {16'd0, ~bits[15], bits[14:0]};
            ST_UINT16: res = {16'd0, bits[15:0]};
            ST_INT32:  res = {~bits[31], bits[30:0]};
            default:   res = bits[31] ? ~bits : {1'b1, bits[30:0]};
        endcase
        return res;
    endfunction

endpackage

// File: rtl/mmdec_store.sv
// Extreme store with read-modify-write merge stage and write-to-read forwarding.
module mmdec_store #(
    parameter int MAX_CHANNELS = mmdec_pkg::MAX_CHANNELS_DEF,
    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  logic [CH_W-1:0]                      in_ch,
    input  mmdec_pkg::item_flags_t               in_flags,
    input  logic [mmdec_pkg::VAL_W-1:0]          in_lo,
    input  logic [mmdec_pkg::VAL_W-1:0]          in_hi,
    input  logic [mmdec_pkg::TYPE_CFG_W-1:0]     sample_type,
    input  logic                                 advance,
    output logic                                 busy,
    output logic [CH_W-1:0]                      res_ch,
    output mmdec_pkg::item_flags_t               res_flags,
    output logic [mmdec_pkg::VAL_W-1:0]          res_min,
    output logic [mmdec_pkg::VAL_W-1:0]          res_max
);
    import mmdec_pkg::*;

    logic [2*VAL_W-1:0] mem [MAX_CHANNELS];

    logic               s1_valid_reg;
    logic [CH_W-1:0]    s1_ch_reg;
    item_flags_t        s1_flags_reg;
    logic [VAL_W-1:0]   s1_lo_reg;
    logic [VAL_W-1:0]   s1_hi_reg;
    logic [2*VAL_W-1:0] rdata_reg;

    logic               fwd_valid_reg;
    logic [CH_W-1:0]    fwd_ch_reg;
    logic [2*VAL_W-1:0] fwd_data_reg;

    logic [2*VAL_W-1:0] base;
    logic [VAL_W-1:0]   cur_min;
    logic [VAL_W-1:0]   cur_max;
    logic               fire;

    assign fire = s1_valid_reg & advance;

    // Read the entry as the beat enters
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rdata_reg <= mem[in_ch];
        end
    end

    // Write the merged pair back as the merge stage retires
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            mem[s1_ch_reg] <= {cur_max, cur_min};
        end
    end

    // Merge stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // Merge stage payload and last-write copy
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_ch_reg    <= in_ch;
            s1_flags_reg <= in_flags;
            s1_lo_reg    <= in_lo;
            s1_hi_reg    <= in_hi;
        end
        if (fire)
        begin
            fwd_ch_reg   <= s1_ch_reg;
            fwd_data_reg <= {cur_max, cur_min};
        end
    end

    // Take the last write when it hit the same entry, else the memory word
    always_comb
    begin
        if (fwd_valid_reg && (fwd_ch_reg == s1_ch_reg))
        begin
            base = fwd_data_reg;
        end
        else
        begin
            base = rdata_reg;
        end
    end

    // Compare in the selected order and keep the extremes
    always_comb
    begin
        cur_min = base[VAL_W-1:0];
        cur_max = base[2*VAL_W-1:VAL_W];
        if (s1_flags_reg.first)
        begin
            cur_min = s1_lo_reg;
            cur_max = s1_hi_reg;
        end
        else
        begin
            if (order_key(s1_lo_reg, sample_type) < order_key(cur_min, sample_type))
            begin
                cur_min = s1_lo_reg;
            end
            if (order_key(s1_hi_reg, sample_type) > order_key(cur_max, sample_type))
            begin
                cur_max = s1_hi_reg;
            end
        end
    end

    assign busy      = s1_valid_reg;
    assign res_ch    = s1_ch_reg;
    assign res_flags = s1_flags_reg;
    assign res_min   = cur_min;
    assign res_max   = cur_max;

endmodule

// File: rtl/multichannel_minmax_decimator_unit.sv
// Top level of the multichannel min/max decimator: config port, counters, output register.
//
// Usage:
//   Input beats on s_* carry one channel-interleaved sample each: tdata holds
//   low_value and high_value, tlast marks the end of a record (drop the partial
//   group and restart both counters after this beat).
//   Output beats on m_* carry one channel's min/max pair at the end of a group;
//   tlast marks the result of the last channel in that group.
//   The APB port sets num_channels (0x0), group_length (0x4), sample_type (0x8);
//   write it only while no beat is in flight.
// Timing:
//   One input beat per cycle while s_tready is high. A beat that closes a group
//   shows its result on m_* once the merge stage advances: the store is read at
//   the accepting edge, and the merge is written back and loaded into the output
//   register as the merge stage advances. The pace is set by the single read and
//   single write port of the extreme store.
// Reset clears counters, pipeline valids and registers to their defaults; the
// store itself holds nothing valid until the first group writes it.
// When the receiver stalls, the output register holds and s_tready stays high
// until the merge stage also holds a result; then s_tready drops.
module multichannel_minmax_decimator_unit #(
    parameter int MAX_CHANNELS = mmdec_pkg::MAX_CHANNELS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // APB configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [3:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    // Input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [mmdec_pkg::IN_TDATA_W-1:0]      s_tdata,  // low_value, high_value
    input  logic                                  s_tlast,  // end_of_record
    // Output stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [mmdec_pkg::OUT_TDATA_W-1:0]     m_tdata,  // channel_index, min, max, pad
    output logic                                  m_tlast   // group_done
);
    import mmdec_pkg::*;

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NCH_W = $clog2(MAX_CHANNELS + 1);
    localparam int CMP_W = (NCH_W > NCH_CFG_W) ? NCH_W : NCH_CFG_W;

    // Configuration registers
    logic [NCH_CFG_W-1:0]  num_channels_reg;
    logic [GLEN_CFG_W-1:0] group_length_reg;
    logic [TYPE_CFG_W-1:0] sample_type_reg;

    // Position counters
    logic [CH_W-1:0]       ch_cnt_reg;
    logic [CH_W-1:0]       ch_cnt_next;
    logic [GLEN_CFG_W-1:0] step_reg;
    logic [GLEN_CFG_W-1:0] step_next;

    // Output register
    logic               out_valid_reg;
    logic [CHIDX_W-1:0] out_ch_reg;
    logic [VAL_W-1:0]   out_min_reg;
    logic [VAL_W-1:0]   out_max_reg;
    logic               out_last_reg;

    logic                  cfg_wr;
    logic [CMP_W-1:0]      nch_raw;
    logic [CMP_W-1:0]      nch_eff;
    logic [GLEN_CFG_W-1:0] glen_eff;
    logic [CH_W-1:0]       ch_sel;
    item_flags_t           flags;
    logic                  in_fire;
    logic [VAL_W-1:0]      lo_masked;
    logic [VAL_W-1:0]      hi_masked;

    logic                  s1_busy;
    logic [CH_W-1:0]       s1_ch;
    item_flags_t           s1_flags;
    logic [VAL_W-1:0]      s1_min;
    logic [VAL_W-1:0]      s1_max;
    logic                  s1_adv;

    // APB write and read
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_channels_reg <= NUM_CHANNELS_RST;
            group_length_reg <= GROUP_LENGTH_RST;
            sample_type_reg  <= SAMPLE_TYPE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_NUM_CHANNELS: num_channels_reg <= pwdata[NCH_CFG_W-1:0];
                REG_GROUP_LENGTH: group_length_reg <= pwdata[GLEN_CFG_W-1:0];
                REG_SAMPLE_TYPE:  sample_type_reg  <= pwdata[TYPE_CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_NUM_CHANNELS: prdata = 32'(num_channels_reg);
            REG_GROUP_LENGTH: prdata = 32'(group_length_reg);
            REG_SAMPLE_TYPE:  prdata = 32'(sample_type_reg);
            default:          prdata = 32'd0;
        endcase
    end

    // Clamp the configured channel count and group length
    assign nch_raw = CMP_W'(num_channels_reg);

    always_comb
    begin
        priority if (nch_raw == '0)
        begin
            nch_eff = CMP_W'(1);
        end
        else if (nch_raw > CMP_W'(MAX_CHANNELS))
        begin
            nch_eff = CMP_W'(MAX_CHANNELS);
        end
        else
        begin
            nch_eff = nch_raw;
        end
    end

    assign glen_eff = (group_length_reg == '0) ? GLEN_CFG_W'(1) : group_length_reg;

    // Place the incoming beat in its group
    always_comb
    begin
        ch_sel = (CMP_W'(ch_cnt_reg) >= nch_eff) ? '0 : ch_cnt_reg;
        flags.first     = (step_reg == '0);
        flags.last_step = ({1'b0, step_reg} + 17'd1) >= {1'b0, glen_eff};
        flags.last_ch   = (CMP_W'(ch_sel) + CMP_W'(1)) >= nch_eff;
    end

    always_comb
    begin
        ch_cnt_next = ch_cnt_reg;
        step_next   = step_reg;
        if (flags.last_ch)
        begin
            ch_cnt_next = '0;
            step_next   = flags.last_step ? '0 : step_reg + GLEN_CFG_W'(1);
        end
        else
        begin
            ch_cnt_next = ch_sel + CH_W'(1);
        end
        if (s_tlast)
        begin
            ch_cnt_next = '0;
            step_next   = '0;
        end
    end

    // Advance counters on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_cnt_reg <= '0;
            step_reg   <= '0;
        end
        else if (in_fire)
        begin
            ch_cnt_reg <= ch_cnt_next;
            step_reg   <= step_next;
        end
    end

    // Handshake: the merge stage moves on unless its result finds the output full and not taken
    assign s1_adv   = s1_busy & (~s1_flags.last_step | ~out_valid_reg | m_tready);
    assign s_tready = ~s1_busy | s1_adv;
    assign in_fire  = s_tvalid & s_tready;

    assign lo_masked = mask_value(s_tdata[VAL_W-1:0], sample_type_reg);
    assign hi_masked = mask_value(s_tdata[2*VAL_W-1:VAL_W], sample_type_reg);

    mmdec_store #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (in_fire),
        .in_ch       (ch_sel),
        .in_flags    (flags),
        .in_lo       (lo_masked),
        .in_hi       (hi_masked),
        .sample_type (sample_type_reg),
        .advance     (s1_adv),
        .busy        (s1_busy),
        .res_ch      (s1_ch),
        .res_flags   (s1_flags),
        .res_min     (s1_min),
        .res_max     (s1_max)
    );

    // Output register: load a finished group result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_flags.last_step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_flags.last_step)
        begin
            out_ch_reg   <= CHIDX_W'(s1_ch);
            out_min_reg  <= s1_min;
            out_max_reg  <= s1_max;
            out_last_reg <= s1_flags.last_ch;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_max_reg, out_min_reg, out_ch_reg};
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/mmdec_checker.sv
// Port-level checks for the min/max decimator, bound to the top level.
module mmdec_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [3:0]                        paddr,
    input logic [31:0]                       prdata,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mmdec_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                              m_tlast
);
    import mmdec_pkg::*;

    // A stalled result beat holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output beat changed");

    // With the output empty the pipeline must take new beats
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output empty");

    // Pad bits above the max field stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_TDATA_W-1:2*VAL_W+CHIDX_W] == '0)
        else $error("output pad bits set");

    // A written sample type reads back within its field width
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[3:2] == REG_SAMPLE_TYPE
        |=> prdata[31:TYPE_CFG_W] == '0 || $past(paddr) != paddr)
        else $error("sample type register wider than its field");

endmodule

bind multichannel_minmax_decimator_unit mmdec_checker u_mmdec_checker (.*);

// File: bench/testbench.sv
// Self-checking bench for the multichannel min/max decimator: directed table, random phases.
module testbench;

    import mmdec_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_SAMPLES = 1200;
    localparam int TIMEOUT_TIME   = 5_000_000;

    // Reserved sample type code that must fall back to float32 order
    localparam logic [TYPE_CFG_W-1:0] ST_RESERVED7 = 3'd7;

    typedef struct {
        logic [CHIDX_W-1:0] chan;
        logic [VAL_W-1:0]   min_v;
        logic [VAL_W-1:0]   max_v;
        logic               done;
    } minmax_t;

    typedef enum {ROW_CONFIG, ROW_SAMPLE, ROW_TYPED} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic [31:0] lo;       // register value on a config row
        logic [31:0] hi;
        bit          eor;
        minmax_t     want;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [3:0]             paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // low_value, high_value
    logic                   s_tlast;   // end_of_record
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // channel_index, min_value, max_value, pad
    logic                   m_tlast;   // group_done

    // Shadow of the block's registers and state
    logic [NCH_CFG_W-1:0]  nch_cfg;
    logic [GLEN_CFG_W-1:0] glen_cfg;
    logic [TYPE_CFG_W-1:0] type_cfg;
    logic [VAL_W-1:0]      store_min [MAX_CHANNELS_DEF];
    logic [VAL_W-1:0]      store_max [MAX_CHANNELS_DEF];
    int unsigned           chan_count;
    int unsigned           step_count;

    minmax_t   pending_pairs[$];
    stim_row_t stim_rows[$];

    int fail_count    = 0;
    int samples_sent  = 0;
    int pairs_checked = 0;
    int gap_pct       = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int holdoffs      = 0;

    logic [31:0] corner_vals [12] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
        32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFC0_0000,
        32'h0000_0080, 32'h0000_8000, 32'h0000_00FF, 32'h0000_FFFF
    };

    multichannel_minmax_decimator_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Keep only the bits that the sample type compares
    function automatic logic [31:0] narrow_bits(input logic [31:0] v,
                                                input logic [TYPE_CFG_W-1:0] st);
        case (st)
            ST_UINT8:            return v & 32'h0000_00FF;
            ST_INT16, ST_UINT16: return v & 32'h0000_FFFF;
            default:             return v;
        endcase
    endfunction

    // Unsigned key whose natural order is the compare order of the type
    function automatic logic [31:0] sort_key(input logic [31:0] v,
                                             input logic [TYPE_CFG_W-1:0] st);
        case (st)
            ST_UINT8:  return v & 32'h0000_00FF;
            ST_INT16:  return (v & 32'h0000_FFFF) ^ 32'h0000_8000;
            ST_UINT16: return v & 32'h0000_FFFF;
            ST_INT32:  return v ^ 32'h8000_0000;
            default:   return v[31] ? ~v : (v | 32'h8000_0000);
        endcase
    endfunction

    function automatic void set_config(input logic [1:0] idx, input logic [31:0] val);
        case (idx)
            REG_NUM_CHANNELS: nch_cfg  = val[NCH_CFG_W-1:0];
            REG_GROUP_LENGTH: glen_cfg = val[GLEN_CFG_W-1:0];
            REG_SAMPLE_TYPE:  type_cfg = val[TYPE_CFG_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] cfg_value(input logic [1:0] idx);
        case (idx)
            REG_NUM_CHANNELS: return {{(32-NCH_CFG_W){1'b0}}, nch_cfg};
            REG_GROUP_LENGTH: return {{(32-GLEN_CFG_W){1'b0}}, glen_cfg};
            REG_SAMPLE_TYPE:  return {{(32-TYPE_CFG_W){1'b0}}, type_cfg};
            default:          return 32'd0;
        endcase
    endfunction

    // Fold one sample into its channel's extremes; return 1 when it closes a group
    function automatic bit fold_sample(input logic [31:0] lo_raw, input logic [31:0] hi_raw,
                                       input bit eor, output minmax_t res);
        int unsigned nch;
        int unsigned glen;
        int unsigned ch;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] cur_min;
        logic [31:0] cur_max;
        bit          first;
        bit          last_step;
        bit          last_ch;
        lo   = narrow_bits(lo_raw, type_cfg);
        hi   = narrow_bits(hi_raw, type_cfg);
        nch  = (nch_cfg == 0) ? 1 : ((nch_cfg > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : nch_cfg);
        glen = (glen_cfg == 0) ? 1 : glen_cfg;
        // a counter left beyond a shrunk channel count restarts at channel 0
        ch        = (chan_count >= nch) ? 0 : chan_count;
        first     = (step_count == 0);
        last_step = (step_count + 1 >= glen);
        last_ch   = (ch + 1 >= nch);
        if (first)
        begin
            cur_min = lo;
            cur_max = hi;
        end
        else
        begin
            cur_min = store_min[ch];
            cur_max = store_max[ch];
            if (sort_key(lo, type_cfg) < sort_key(cur_min, type_cfg))
                cur_min = lo;
            if (sort_key(hi, type_cfg) > sort_key(cur_max, type_cfg))
                cur_max = hi;
        end
        store_min[ch] = cur_min;
        store_max[ch] = cur_max;
        res.chan  = ch[CHIDX_W-1:0];
        res.min_v = cur_min;
        res.max_v = cur_max;
        res.done  = last_ch;
        // advance the counters; a record end clears them after the result
        if (last_ch)
        begin
            chan_count = 0;
            step_count = last_step ? 0 : ((step_count + 1) & 32'h0000_FFFF);
        end
        else
        begin
            chan_count = (ch + 1) & 32'h3F;
        end
        if (eor)
        begin
            chan_count = 0;
            step_count = 0;
        end
        return last_step;
    endfunction

    function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [31:0] val);
        stim_row_t r;
        r.kind    = ROW_CONFIG;
        r.reg_idx = idx;
        r.lo      = val;
        r.hi      = 32'd0;
        r.eor     = 1'b0;
        return r;
    endfunction

    function automatic stim_row_t smp_row(input logic [31:0] lo, input logic [31:0] hi,
                                          input bit eor);
        stim_row_t r;
        r.kind    = ROW_SAMPLE;
        r.reg_idx = REG_NUM_CHANNELS;
        r.lo      = lo;
        r.hi      = hi;
        r.eor     = eor;
        return r;
    endfunction

    function automatic stim_row_t chk_row(input logic [31:0] lo, input logic [31:0] hi,
                                          input logic [31:0] mn, input logic [31:0] mx);
        stim_row_t r;
        r = smp_row(lo, hi, 1'b0);
        r.kind       = ROW_TYPED;
        r.want.chan  = '0;
        r.want.min_v = mn;
        r.want.max_v = mx;
        r.want.done  = 1'b1;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        if ($urandom_range(3) == 0)
            return corner_vals[$urandom_range(11)];
        return $urandom();
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%h, got 0x%h", name, want, got);
            fail_count++;
        end
    endfunction

    // Raw sample, cascaded pair ordered by the compare order, or an unrelated pair
    task automatic pick_pair(output logic [31:0] lo, output logic [31:0] hi);
        logic [31:0] a;
        logic [31:0] b;
        int unsigned how;
        how = $urandom_range(9);
        a   = rand_word();
        b   = rand_word();
        if (how < 4)
        begin
            lo = a;
            hi = a;
        end
        else if (how < 8 && sort_key(a, type_cfg) > sort_key(b, type_cfg))
        begin
            lo = b;
            hi = a;
        end
        else
        begin
            lo = a;
            hi = b;
        end
    endtask

    // One APB transfer: setup, then access until pready, then psel drops and the bus idles
    task automatic apb_access(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        if (wr)
            set_config(idx, wdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_readback(input logic [1:0] idx);
        logic [31:0] rd;
        apb_access(1'b0, idx, 32'd0, rd);
        if (rd !== cfg_value(idx))
        begin
            $error("prdata at register %0d: expected 0x%h, got 0x%h", idx, cfg_value(idx), rd);
            fail_count++;
        end
    endtask

    task automatic program_reg(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] rd;
        apb_access(1'b1, idx, val, rd);
        check_readback(idx);
    endtask

    // Offer one beat, with random gaps ahead of it, and predict once accepted
    task automatic send_sample(input logic [31:0] lo, input logic [31:0] hi, input bit eor,
                               input bit typed, input minmax_t want);
        minmax_t res;
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hi, lo};
        s_tlast  <= eor;
        do
            @(posedge clk);
        while (!s_tready);
        if (fold_sample(lo, hi, eor, res))
            pending_pairs.push_back(typed ? want : res);
        samples_sent++;
        @(negedge clk);
    endtask

    // Hold the input until every expected pair is out and the pipeline has settled
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_pairs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_TIME);
        $display("** multichannel_minmax_decimator_unit: FAILED **");
        $finish;
    end

    // Output side: random stalls, plus long hold-offs on request
    initial
    begin : sink_side
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Compare each output beat with the oldest expected pair
    always @(posedge clk)
    begin
        minmax_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pairs.size() == 0)
            begin
                $error("unexpected result beat: channel_index %0d", m_tdata[5:0]);
                fail_count++;
            end
            else
            begin
                want = pending_pairs.pop_front();
                compare_field("channel_index", want.chan, m_tdata[5:0]);
                compare_field("min_value", want.min_v, m_tdata[37:6]);
                compare_field("max_value", want.max_v, m_tdata[69:38]);
                compare_field("group_done", want.done, m_tlast);
                pairs_checked++;
            end
        end
    end

    initial
    begin
        logic [1:0]  reg_list [3];
        minmax_t     no_pair;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] nch_w;
        logic [31:0] glen_w;
        logic [31:0] type_w;
        int unsigned neff;
        int unsigned geff;
        int unsigned span;
        int unsigned n_items;
        int          directed_count;
        int          phase;

        reg_list = '{REG_NUM_CHANNELS, REG_GROUP_LENGTH, REG_SAMPLE_TYPE};
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;

        nch_cfg    = NUM_CHANNELS_RST;
        glen_cfg   = GROUP_LENGTH_RST;
        type_cfg   = SAMPLE_TYPE_RST;
        chan_count = 0;
        step_count = 0;
        foreach (store_min[i])
        begin
            store_min[i] = '0;
            store_max[i] = '0;
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // registers read back their reset values
        foreach (reg_list[i])
            check_readback(reg_list[i]);

        // Directed table: float order at reset settings, narrow types, corner settings,
        // record ends, then counters left beyond a shrunk configuration
        stim_rows.push_back(smp_row(32'h3F80_0000, 32'h3F80_0000, 1'b0));
        stim_rows.push_back(smp_row(32'h8000_0000, 32'h0000_0000, 1'b0));
        stim_rows.push_back(smp_row(32'hFF80_0000, 32'h7F80_0000, 1'b0));
        stim_rows.push_back(chk_row(32'hFFC0_0000, 32'h7FC0_0000, 32'hFFC0_0000, 32'h7FC0_0000));
        stim_rows.push_back(cfg_row(REG_GROUP_LENGTH, 32'd1));
        stim_rows.push_back(cfg_row(REG_SAMPLE_TYPE, ST_UINT8));
        stim_rows.push_back(chk_row(32'hFFFF_FF00, 32'h1234_56FF, 32'h0000_0000, 32'h0000_00FF));
        stim_rows.push_back(cfg_row(REG_SAMPLE_TYPE, ST_INT16));
        stim_rows.push_back(chk_row(32'h0000_8000, 32'hFFFF_7FFF, 32'h0000_8000, 32'h0000_7FFF));
        stim_rows.push_back(cfg_row(REG_SAMPLE_TYPE, ST_UINT16));
        stim_rows.push_back(chk_row(32'hABCD_0000, 32'h0000_FFFF, 32'h0000_0000, 32'h0000_FFFF));
        stim_rows.push_back(cfg_row(REG_SAMPLE_TYPE, ST_INT32));
        stim_rows.push_back(chk_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        stim_rows.push_back(cfg_row(REG_SAMPLE_TYPE, ST_RESERVED7));
        stim_rows.push_back(cfg_row(REG_GROUP_LENGTH, 32'd0));
        stim_rows.push_back(chk_row(32'h0000_0001, 32'h8000_0001, 32'h0000_0001, 32'h8000_0001));
        stim_rows.push_back(cfg_row(REG_NUM_CHANNELS, 32'd3));
        stim_rows.push_back(cfg_row(REG_GROUP_LENGTH, 32'd2));
        stim_rows.push_back(cfg_row(REG_SAMPLE_TYPE, ST_INT32));
        stim_rows.push_back(smp_row(32'h0000_0005, 32'h0000_0005, 1'b0));
        stim_rows.push_back(smp_row(32'hFFFF_FFF0, 32'hFFFF_FFF0, 1'b0));
        stim_rows.push_back(smp_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
        stim_rows.push_back(smp_row(32'hFFFF_FFFF, 32'h0000_0010, 1'b0));
        stim_rows.push_back(smp_row(32'h0000_0000, 32'h0000_0000, 1'b0));
        stim_rows.push_back(smp_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
        stim_rows.push_back(smp_row(32'h1111_1111, 32'h2222_2222, 1'b0));
        stim_rows.push_back(smp_row(32'h3333_3333, 32'h4444_4444, 1'b1));
        stim_rows.push_back(cfg_row(REG_GROUP_LENGTH, 32'd3));
        stim_rows.push_back(smp_row(32'h0000_0001, 32'h0000_0001, 1'b0));
        stim_rows.push_back(smp_row(32'h0000_0002, 32'h0000_0002, 1'b0));
        stim_rows.push_back(smp_row(32'h0000_0003, 32'h0000_0003, 1'b0));
        stim_rows.push_back(smp_row(32'h0000_0000, 32'h0000_0009, 1'b0));
        stim_rows.push_back(smp_row(32'h0000_0005, 32'h0000_0006, 1'b0));
        stim_rows.push_back(cfg_row(REG_NUM_CHANNELS, 32'd2));
        stim_rows.push_back(cfg_row(REG_GROUP_LENGTH, 32'd1));
        stim_rows.push_back(smp_row(32'h0000_0007, 32'h0000_0008, 1'b0));
        stim_rows.push_back(smp_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));

        foreach (stim_rows[i])
        begin
            case (stim_rows[i].kind)
                ROW_CONFIG:
                begin
                    wait_idle();
                    program_reg(stim_rows[i].reg_idx, stim_rows[i].lo);
                end
                ROW_SAMPLE:
                    send_sample(stim_rows[i].lo, stim_rows[i].hi, stim_rows[i].eor,
                                1'b0, stim_rows[i].want);
                default:
                    send_sample(stim_rows[i].lo, stim_rows[i].hi, stim_rows[i].eor,
                                1'b1, stim_rows[i].want);
            endcase
        end
        directed_count = samples_sent;

        // Random phases: new settings while idle, then samples closed by a record end
        phase = 0;
        while (samples_sent < directed_count + RANDOM_SAMPLES)
        begin
            wait_idle();
            case ($urandom_range(19))
                0:       nch_w = 32'd0;
                1:       nch_w = MAX_CHANNELS_DEF;
                2:       nch_w = $urandom_range(127, 65);
                3, 4, 5: nch_w = $urandom_range(20, 5);
                default: nch_w = $urandom_range(4, 1);
            endcase
            case ($urandom_range(19))
                0:       glen_w = 32'd0;
                1:       glen_w = 32'd65535;
                2, 3:    glen_w = $urandom_range(40, 7);
                default: glen_w = $urandom_range(6, 1);
            endcase
            type_w = $urandom_range(7);
            program_reg(REG_NUM_CHANNELS, nch_w);
            program_reg(REG_GROUP_LENGTH, glen_w);
            program_reg(REG_SAMPLE_TYPE, type_w);

            neff = (nch_w == 0) ? 1 : ((nch_w > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : nch_w);
            geff = (glen_w == 0) ? 1 : glen_w;
            span = neff * geff;
            // long groups are only started, never finished
            n_items = (span <= 60) ? span * $urandom_range(60 / span, 1) : $urandom_range(60, 20);

            case (phase % 4)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 69;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 69;
                end
                default:
                begin
                    gap_pct   = 29;
                    stall_pct = 29;
                end
            endcase
            // starve the output for a long stretch while beats keep coming
            if (phase % 5 == 2)
            begin
                hold_req++;
                holdoffs++;
            end

            for (int k = 0; k < n_items; k++)
            begin
                pick_pair(lo, hi);
                send_sample(lo, hi, (k == n_items - 1) || ($urandom_range(24) == 0),
                            1'b0, no_pair);
            end
            phase++;
        end

        wait_idle();
        $display("Run covered %0d samples (%0d directed) over %0d random settings of all registers.",
                 samples_sent, directed_count, phase);
        $display("%0d min/max pairs checked; %0d long output hold-offs with input pressure.",
                 pairs_checked, holdoffs);
        if (fail_count == 0 && pending_pairs.size() == 0)
            $display("** multichannel_minmax_decimator_unit: PASSED **");
        else
            $display("** multichannel_minmax_decimator_unit: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
rtl/mmdec_pkg.sv
rtl/mmdec_store.sv
rtl/multichannel_minmax_decimator_unit.sv
rtl/mmdec_checker.sv
bench/testbench.sv
